FILE: sv/ipv4dq_pkg.sv
package ipv4dq_pkg;

  localparam logic [7:0] CH_ZERO = 8'h30;
  localparam logic [7:0] CH_NINE = 8'h39;
  localparam logic [7:0] CH_DOT  = 8'h2e;

  localparam logic [11:0] OCTET_MAX   = 12'd255;
  localparam logic [2:0]  DOTS_NEEDED = 3'd3;
  localparam logic [2:0]  DOT_SAT     = 3'd4;
  localparam logic [1:0]  DIGIT_SAT   = 2'd2;

  // one character or end marker leaving the input register
  typedef struct packed {
    logic fire;
    logic eot;
  } step_t;

endpackage

FILE: sv/ipv4_dotted_quad_validator_top.sv
// ipv4 dotted-quad validator: one character word per cycle, end marker word closes the string
// verdict is registered on valid_res when the end marker word leaves the input register
// one word per cycle unless in_stall; input register feeds the scan into the result register
// an end marker word waits in the input register only while an earlier verdict is stalled
// reset (rst, synchronous) empties both registers and clears the scan state
module ipv4_dotted_quad_validator_top (
  input  logic       clk,
  input  logic       rst,
  input  logic [7:0] ch,
  input  logic       end_of_text,
  input  logic       in_valid,
  output logic       in_stall,
  output logic       valid_res,
  output logic       out_valid,
  input  logic       out_stall
);
  import ipv4dq_pkg::*;

  logic       q_valid;
  logic [7:0] q_ch;
  logic       q_eot;
  logic       out_free;
  logic       consume;
  logic       load;
  logic       ok;
  step_t      step;

  assign out_free = !out_valid || !out_stall;
  assign consume  = q_valid && (!q_eot || out_free);
  assign in_stall = q_valid && !consume;
  assign load     = in_valid && !in_stall;

  assign step.fire = consume;
  assign step.eot  = q_eot;

  always_ff @(posedge clk) begin
    if (rst) begin
      q_valid <= 1'b0;
    end else if (load) begin
      q_valid <= 1'b1;
    end else if (consume) begin
      q_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      q_ch  <= ch;
      q_eot <= end_of_text;
    end
  end

  ipv4dq_scan u_scan (
    .clk  (clk),
    .rst  (rst),
    .step (step),
    .ch   (q_ch),
    .ok   (ok)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (consume && q_eot) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (consume && q_eot) begin
      valid_res <= ok;
    end
  end

  a_stall_only_on_end: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> q_valid && q_eot && out_valid && out_stall)
    else $error("input stalled without a blocked verdict");

  a_verdict_from_end: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(consume && q_eot))
    else $error("verdict without an end marker");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |-> !(consume && q_eot))
    else $error("stalled verdict overwritten");

endmodule

FILE: sv/ipv4dq_scan.sv
module ipv4dq_scan (
  input  logic                clk,
  input  logic                rst,
  input  ipv4dq_pkg::step_t   step,
  input  logic [7:0]          ch,
  output logic                ok
);
  import ipv4dq_pkg::*;

  logic [7:0]  octet_value, octet_value_next;
  logic [1:0]  digit_count, digit_count_next;
  logic [2:0]  dot_count, dot_count_next;
  logic        first_digit_zero, first_digit_zero_next;
  logic        failed, failed_next;

  logic        lead_bad;
  logic        is_digit;
  logic [3:0]  dval;
  logic [11:0] sum;

  assign lead_bad = (digit_count >= DIGIT_SAT) && first_digit_zero;
  assign is_digit = (ch >= CH_ZERO) && (ch <= CH_NINE);
  assign dval     = 4'(ch - CH_ZERO);
  assign sum      = 12'(octet_value) * 12'd10 + 12'(dval);

  assign ok = !failed && (dot_count == DOTS_NEEDED) && (digit_count != 2'd0) && !lead_bad;

  always_comb begin
    octet_value_next      = octet_value;
    digit_count_next      = digit_count;
    dot_count_next        = dot_count;
    first_digit_zero_next = first_digit_zero;
    failed_next           = failed;
    if (step.fire) begin
      if (step.eot) begin
        octet_value_next      = '0;
        digit_count_next      = '0;
        dot_count_next        = '0;
        first_digit_zero_next = 1'b0;
        failed_next           = 1'b0;
      end else if (!failed) begin
        if (ch == CH_DOT) begin
          if (digit_count == 2'd0 || lead_bad) begin
            failed_next = 1'b1;
          end
          if (dot_count < DOT_SAT) begin
            dot_count_next = dot_count + 3'd1;
          end
          octet_value_next      = '0;
          digit_count_next      = '0;
          first_digit_zero_next = 1'b0;
        end else if (!is_digit) begin
          failed_next = 1'b1;
        end else if (sum > OCTET_MAX) begin
          failed_next = 1'b1;
        end else begin
          octet_value_next = sum[7:0];
          if (digit_count == 2'd0) begin
            first_digit_zero_next = (dval == 4'd0);
          end
          if (digit_count < DIGIT_SAT) begin
            digit_count_next = digit_count + 2'd1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      octet_value      <= '0;
      digit_count      <= '0;
      dot_count        <= '0;
      first_digit_zero <= 1'b0;
      failed           <= 1'b0;
    end else begin
      octet_value      <= octet_value_next;
      digit_count      <= digit_count_next;
      dot_count        <= dot_count_next;
      first_digit_zero <= first_digit_zero_next;
      failed           <= failed_next;
    end
  end

  a_counts_sat: assert property (@(posedge clk) disable iff (rst)
    dot_count <= DOT_SAT && digit_count <= DIGIT_SAT)
    else $error("scan counter past saturation");

  a_clear_after_end: assert property (@(posedge clk) disable iff (rst)
    step.fire && step.eot |=> dot_count == 3'd0 && digit_count == 2'd0 && !failed)
    else $error("scan state not cleared after end marker");

  a_failed_sticky: assert property (@(posedge clk) disable iff (rst)
    failed && !(step.fire && step.eot) |=> failed)
    else $error("failed flag dropped before end marker");

endmodule
